// ===== hdl/assert_macros.svh =====
// Assertion macros used by the flow table RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every clock edge outside reset
`define FPTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every clock edge, reset included
`define FPTT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hdl/fptt_pkg.sv =====
// Types, constants and widths of the flow pair traffic table
`default_nettype none
package fptt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RD_CMP_W    = (IDX_W > 8) ? IDX_W : 8;
  localparam int HDR_SHIFT   = 2;   // header fields count 4-byte words

  typedef enum logic [2:0] {
    ST_HIT    = 3'd0,
    ST_NEW    = 3'd1,
    ST_SKIP   = 3'd2,
    ST_FULL   = 3'd3,
    ST_READ   = 3'd4,
    ST_UNUSED = 3'd5
  } status_t;

  typedef struct packed {
    logic        op;
    logic        is_tcp;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] ip_total_len;
    logic [3:0]  ip_header_words;
    logic [3:0]  tcp_offset_words;
    logic [7:0]  read_index;
  } cmd_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  entry_index;
    logic [31:0] entry_src;
    logic [31:0] entry_dst;
    logic [31:0] entry_packets;
    logic [31:0] entry_volume;
    logic [8:0]  entries_used;
  } res_t;

  // item travelling along the cell row
  typedef struct packed {
    logic             vld;
    logic             op;
    logic             tcp;
    logic [31:0]      src;
    logic [31:0]      dst;
    logic [15:0]      pay;
    logic [7:0]       ridx;
    logic             done;    // some cell has answered
    logic             fresh;   // answer came from a newly claimed slot
    logic [7:0]       idx;
    logic [CNT_W-1:0] count;   // used slots seen so far
    logic [31:0]      esrc;
    logic [31:0]      edst;
    logic [31:0]      pkts;
    logic [31:0]      vol;
  } token_t;

endpackage
`default_nettype wire

// ===== hdl/fptt_cell.sv =====
// One table slot plus its pipeline register in the cell row
`default_nettype none
module fptt_cell
  import fptt_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire token_t           tok_in,
  output token_t                tok_out,
  output logic                  used
);

  logic        used_next;
  logic [31:0] src, src_next;
  logic [31:0] dst, dst_next;
  logic [31:0] pkts, pkts_next;
  logic [31:0] vol, vol_next;
  logic        acct, hit, claim, rd;
  token_t      tok_next;

  assign acct  = tok_in.vld && !tok_in.op && tok_in.tcp && !tok_in.done;
  assign hit   = acct && used && (src == tok_in.src) && (dst == tok_in.dst);
  assign claim = acct && !used;
  assign rd    = tok_in.vld && tok_in.op && used &&
                 (RD_CMP_W'(cell_idx) == RD_CMP_W'(tok_in.ridx));

  always_comb begin
    used_next = used;
    src_next  = src;
    dst_next  = dst;
    pkts_next = pkts;
    vol_next  = vol;
    tok_next  = tok_in;
    if (hit) begin
      pkts_next = pkts + 32'd1;
      vol_next  = vol + 32'(tok_in.pay);
    end
    if (claim) begin
      used_next = 1'b1;
      src_next  = tok_in.src;
      dst_next  = tok_in.dst;
      pkts_next = 32'd1;
      vol_next  = 32'(tok_in.pay);
    end
    if (used_next) begin
      tok_next.count = tok_in.count + 1'b1;
    end
    if (hit || claim || rd) begin
      tok_next.done  = 1'b1;
      tok_next.fresh = claim;
      tok_next.idx   = 8'(cell_idx);
      tok_next.esrc  = src_next;
      tok_next.edst  = dst_next;
      tok_next.pkts  = pkts_next;
      tok_next.vol   = vol_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used        <= 1'b0;
      tok_out.vld <= 1'b0;
    end else if (advance) begin
      used    <= used_next;
      tok_out <= tok_next;
    end
  end

  // slot contents: written only when claimed or hit
  always_ff @(posedge clk) begin
    if (advance) begin
      src  <= src_next;
      dst  <= dst_next;
      pkts <= pkts_next;
      vol  <= vol_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fptt_out_stage.sv =====
// Result formatting and output register at the end of the cell row
`default_nettype none
module fptt_out_stage
  import fptt_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire token_t tok,
  output logic        advance,
  output logic        res_valid,
  input  wire logic   res_ready,
  output res_t        res
);

  res_t res_next;

  assign advance = !res_valid || res_ready;

  always_comb begin
    res_next              = '0;
    res_next.entries_used = 9'(tok.count);
    if (tok.op) begin
      res_next.entry_index = tok.ridx;
      res_next.status      = tok.done ? ST_READ : ST_UNUSED;
    end else if (!tok.tcp) begin
      res_next.status = ST_SKIP;
    end else if (tok.done) begin
      res_next.status      = tok.fresh ? ST_NEW : ST_HIT;
      res_next.entry_index = tok.idx;
    end else begin
      res_next.status = ST_FULL;
    end
    if (tok.done) begin
      res_next.entry_src     = tok.esrc;
      res_next.entry_dst     = tok.edst;
      res_next.entry_packets = tok.pkts;
      res_next.entry_volume  = tok.vol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= tok.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/flow_pair_traffic_table_unit.sv =====
// Top level of the flow pair traffic table: cell row and output stage
// Path: an accepted item passes every cell register, then the output register.
// Throughput: one item per cycle; the whole row moves in lockstep and stalls
// only while a result waits in the output register.
// Reset: clears the slot-used bits and all item valid bits; slot contents
// are left as they are and are never read before being written.
`default_nettype none
`include "assert_macros.svh"
module flow_pair_traffic_table_unit
  import fptt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cmd_valid,
  output logic      cmd_ready,
  input  wire cmd_t cmd,
  output logic      res_valid,
  input  wire logic res_ready,
  output res_t      res
);

  // tok[0] is the item entering cell 0; tok[g+1] is cell g's register
  token_t                 tok [TABLE_DEPTH+1];
  logic [TABLE_DEPTH-1:0] used_mask;
  logic                   advance;
  logic [6:0]             hdr_bytes;
  logic [15:0]            pay;

  // Header bytes = 4 * (IP header words + TCP offset words), at most 120.
  // Payload clamps at zero when the headers claim more than the total length.
  assign hdr_bytes = 7'({1'b0, cmd.ip_header_words} + {1'b0, cmd.tcp_offset_words})
                     << HDR_SHIFT;
  assign pay       = (cmd.ip_total_len > 16'(hdr_bytes))
                     ? cmd.ip_total_len - 16'(hdr_bytes) : 16'd0;

  // Whole row shifts when the output register can take the item at the end.
  assign cmd_ready = advance;

  always_comb begin
    tok[0]       = '0;
    tok[0].vld   = cmd_valid;
    tok[0].op    = cmd.op;
    tok[0].tcp   = cmd.is_tcp;
    tok[0].src   = cmd.src_addr;
    tok[0].dst   = cmd.dst_addr;
    tok[0].pay   = pay;
    tok[0].ridx  = cmd.read_index;
  end

  // Each cell owns one slot. An item passes every cell in order, so a slot
  // always sees the items in acceptance order; the first free slot reached
  // by an unmatched TCP packet claims it, which keeps the used slots a prefix.
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    fptt_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .advance  (advance),
      .cell_idx (IDX_W'(g)),
      .tok_in   (tok[g]),
      .tok_out  (tok[g+1]),
      .used     (used_mask[g])
    );
  end

  fptt_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .tok       (tok[TABLE_DEPTH]),
    .advance   (advance),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // used slots always form a contiguous run from slot 0
  `FPTT_ASSERT(a_used_prefix, (used_mask & (used_mask + 1'b1)) == '0, "used slots not a prefix")
  // a packet that found no slot at the end of the row means every slot is taken
  `FPTT_ASSERT(a_full_only_when_full, (tok[TABLE_DEPTH].vld && !tok[TABLE_DEPTH].op && tok[TABLE_DEPTH].tcp && !tok[TABLE_DEPTH].done) |-> (&used_mask), "unplaced packet with free slot")
  // nothing is presented in the cycle after reset
  `FPTT_ASSERT_ALWAYS(a_quiet_after_reset, $past(rst) |-> !res_valid, "result valid after reset")

endmodule
`default_nettype wire
